[sv/time_ordered_event_queue_macros.svh]
// assertion macros shared by the event queue rtl
// needs a clock clk_i and an active-low reset rst_ni in the using module
`ifndef TIME_ORDERED_EVENT_QUEUE_MACROS_SVH
`define TIME_ORDERED_EVENT_QUEUE_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define TOEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define TOEQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[sv/toeq_pkg.sv]
// shared types and codes for the time ordered event queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package toeq_pkg;

  // default sizes
  localparam int CAPACITY_DEF  = 64;
  localparam int TIME_BITS_DEF = 48;
  localparam int TAG_BITS_DEF  = 8;

  // fixed field widths
  localparam int ACTION_BITS = 2;
  localparam int STATUS_BITS = 2;
  localparam int OCC_BITS    = 7;

  // actions carried by an input transfer
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd3;

  // command broadcast to every cell
  typedef struct packed {
    action_e action;
    logic    full;
  } cell_cmd_t;

  // flags a cell shows to its neighbors and to the control
  typedef struct packed {
    logic valid;
    logic keep;   // holds an event with time <= incoming time
    logic match;  // holds an event with the incoming tag
  } cell_flags_t;

endpackage

`default_nettype wire

[sv/time_ordered_event_queue.sv]
// time ordered event queue: sorted chain of cells with a registered result
// depends on toeq_pkg, toeq_cell, toeq_first_hit and the assertion macro header
//
// usage
//   input channel  (in_valid_i / in_stall_o): action_i, event_time_i, event_tag_i
//   output channel (out_valid_o / out_stall_i): status_o, out_time_o, out_tag_o,
//   occupancy_o; every input transfer gives exactly one result transfer
//   insert puts the event behind all stored events of equal or earlier time,
//   pop returns the earliest event, remove deletes the first event with the tag
//   result: registered; it sits in the output register from the cycle after the input
//   transfer
//   throughput: one item per cycle while the output is not stalled; every cell compares against the incoming
//   event and moves its slot in the same cycle, and remove finds the first tag
//   match through a log2(CAPACITY) deep prefix or
//   stall: while the output register holds a result that is stalled, in_stall_o
//   is high and the queue does not change
//   reset: all slots empty, occupancy zero, no result pending; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "time_ordered_event_queue_macros.svh"

module time_ordered_event_queue #(
  parameter int CAPACITY  = toeq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = toeq_pkg::TIME_BITS_DEF,
  parameter int TAG_BITS  = toeq_pkg::TAG_BITS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [toeq_pkg::ACTION_BITS-1:0] action_i,
  input  wire logic [TIME_BITS-1:0]             event_time_i,
  input  wire logic [TAG_BITS-1:0]              event_tag_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [toeq_pkg::STATUS_BITS-1:0]      status_o,
  output logic [TIME_BITS-1:0]                  out_time_o,
  output logic [TAG_BITS-1:0]                   out_tag_o,
  output logic [toeq_pkg::OCC_BITS-1:0]         occupancy_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  toeq_pkg::action_e     action;
  toeq_pkg::cell_cmd_t   cmd;
  toeq_pkg::cell_flags_t flags [CAPACITY];
  logic [TIME_BITS-1:0]  cell_time [CAPACITY];
  logic [TAG_BITS-1:0]   cell_tag [CAPACITY];
  logic [CAPACITY-1:0]   valid_vec;
  logic [CAPACITY-1:0]   match_vec;
  logic [CAPACITY-1:0]   hit_vec;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  found;

  logic                            out_valid_q;
  logic [toeq_pkg::STATUS_BITS-1:0] status_q, status_d;
  logic [TIME_BITS-1:0]            out_time_q, out_time_d;
  logic [TAG_BITS-1:0]             out_tag_q, out_tag_d;
  logic [CNT_W-1:0]                count_q, count_d;

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign action     = toeq_pkg::action_e'(action_i);

  // queue state summary
  assign full  = flags[CAPACITY-1].valid;
  assign empty = !flags[0].valid;
  assign found = hit_vec[CAPACITY-1];

  // broadcast command, idle unless a transfer happens
  assign cmd.action = accept ? action : toeq_pkg::ACT_NOP;
  assign cmd.full   = full;

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    toeq_pkg::cell_flags_t left_flags, right_flags;
    logic [TIME_BITS-1:0]  left_time, right_time;
    logic [TAG_BITS-1:0]   left_tag, right_tag;

    if (i == 0) begin : g_head
      assign left_flags = '{valid: 1'b1, keep: 1'b1, match: 1'b0};
      assign left_time  = '0;
      assign left_tag   = '0;
    end else begin : g_body
      assign left_flags = flags[i-1];
      assign left_time  = cell_time[i-1];
      assign left_tag   = cell_tag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_flags = '{valid: 1'b0, keep: 1'b0, match: 1'b0};
      assign right_time  = '0;
      assign right_tag   = '0;
    end else begin : g_inner
      assign right_flags = flags[i+1];
      assign right_time  = cell_time[i+1];
      assign right_tag   = cell_tag[i+1];
    end

    toeq_cell #(
      .TIME_BITS(TIME_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .new_time_i   (event_time_i),
      .new_tag_i    (event_tag_i),
      .first_hit_i  (hit_vec[i]),
      .left_flags_i (left_flags),
      .left_time_i  (left_time),
      .left_tag_i   (left_tag),
      .right_flags_i(right_flags),
      .right_time_i (right_time),
      .right_tag_i  (right_tag),
      .flags_o      (flags[i]),
      .time_o       (cell_time[i]),
      .tag_o        (cell_tag[i])
    );

    assign valid_vec[i] = flags[i].valid;
    assign match_vec[i] = flags[i].match;
  end

  // first tag match for remove
  toeq_first_hit #(
    .N(CAPACITY)
  ) u_first_hit (
    .match_i(match_vec),
    .hit_o  (hit_vec)
  );

  // result and occupancy
  always_comb begin
    status_d   = toeq_pkg::ST_OK;
    out_time_d = '0;
    out_tag_d  = '0;
    count_d    = count_q;
    case (action)
      toeq_pkg::ACT_INSERT: begin
        if (full) begin
          status_d = toeq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      toeq_pkg::ACT_POP: begin
        if (empty) begin
          status_d = toeq_pkg::ST_EMPTY;
        end else begin
          out_time_d = cell_time[0];
          out_tag_d  = cell_tag[0];
          count_d    = count_q - CNT_W'(1);
        end
      end
      toeq_pkg::ACT_REMOVE: begin
        if (found) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = toeq_pkg::ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      out_time_q <= out_time_d;
      out_tag_q  <= out_tag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_time_o  = out_time_q;
  assign out_tag_o   = out_tag_q;
  assign occupancy_o = toeq_pkg::OCC_BITS'(count_q);

  // checks
  `TOEQ_ASSERT(a_valid_packed, ((valid_vec & (valid_vec + CAPACITY'(1))) == '0), "occupied slots not contiguous")
  `TOEQ_ASSERT(a_count_match, (count_q == CNT_W'($countones(valid_vec))), "count disagrees with cell valid bits")
  `TOEQ_ASSERT(a_full_drop, (accept && action == toeq_pkg::ACT_INSERT && full |=> status_q == toeq_pkg::ST_FULL && $stable(count_q)), "insert into full queue not dropped")
  `TOEQ_ASSERT(a_pop_empty, (accept && action == toeq_pkg::ACT_POP && empty |=> status_q == toeq_pkg::ST_EMPTY && out_time_q == '0 && out_tag_q == '0), "pop on empty queue returned data")
  `TOEQ_ASSERT_NEVER(a_full_status, (out_valid_q && status_q == toeq_pkg::ST_FULL && count_q != CNT_W'(CAPACITY)), "full status while queue not full")

endmodule

`default_nettype wire

[sv/toeq_cell.sv]
// one slot of the sorted event chain: valid bit, time and tag
// depends on toeq_pkg
`timescale 1ns / 1ps
`default_nettype none

module toeq_cell #(
  parameter int TIME_BITS = toeq_pkg::TIME_BITS_DEF,
  parameter int TAG_BITS  = toeq_pkg::TAG_BITS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire toeq_pkg::cell_cmd_t   cmd_i,
  input  wire logic [TIME_BITS-1:0]  new_time_i,
  input  wire logic [TAG_BITS-1:0]   new_tag_i,
  input  wire logic                  first_hit_i,
  input  wire toeq_pkg::cell_flags_t left_flags_i,
  input  wire logic [TIME_BITS-1:0]  left_time_i,
  input  wire logic [TAG_BITS-1:0]   left_tag_i,
  input  wire toeq_pkg::cell_flags_t right_flags_i,
  input  wire logic [TIME_BITS-1:0]  right_time_i,
  input  wire logic [TAG_BITS-1:0]   right_tag_i,
  output toeq_pkg::cell_flags_t      flags_o,
  output logic [TIME_BITS-1:0]       time_o,
  output logic [TAG_BITS-1:0]        tag_o
);

  logic                 valid_q, valid_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic                 keep;

  // local compares against the broadcast event
  assign keep          = valid_q && (time_q <= new_time_i);
  assign flags_o.valid = valid_q;
  assign flags_o.keep  = keep;
  assign flags_o.match = valid_q && (tag_q == new_tag_i);
  assign time_o        = time_q;
  assign tag_o         = tag_q;

  // next slot contents
  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    tag_d   = tag_q;
    case (cmd_i.action)
      toeq_pkg::ACT_INSERT: begin
        if (!cmd_i.full && !keep) begin
          if (left_flags_i.keep) begin
            valid_d = 1'b1;
            time_d  = new_time_i;
            tag_d   = new_tag_i;
          end else begin
            valid_d = left_flags_i.valid;
            time_d  = left_time_i;
            tag_d   = left_tag_i;
          end
        end
      end
      toeq_pkg::ACT_POP: begin
        valid_d = right_flags_i.valid;
        time_d  = right_time_i;
        tag_d   = right_tag_i;
      end
      toeq_pkg::ACT_REMOVE: begin
        if (first_hit_i) begin
          valid_d = right_flags_i.valid;
          time_d  = right_time_i;
          tag_d   = right_tag_i;
        end
      end
      default: begin
      end
    endcase
  end

  // occupancy bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    tag_q  <= tag_d;
  end

endmodule

`default_nettype wire

[sv/toeq_first_hit.sv]
// prefix or over the cell match flags: marks the first match and every slot after it
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module toeq_first_hit #(
  parameter int N = 64
) (
  input  wire logic [N-1:0] match_i,
  output logic [N-1:0]      hit_o
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [LEVELS+1];

  // log-depth prefix or
  always_comb begin
    lvl[0] = match_i;
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < N; i++) begin
        if (i >= (1 << l)) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1 << l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  assign hit_o = lvl[LEVELS];

endmodule

`default_nettype wire

[dv/time_ordered_event_queue_tb.sv]
// self-checking testbench for the time ordered event queue
// depends on toeq_pkg and time_ordered_event_queue; keeps a shadow sorted queue to predict results
`timescale 1ns / 1ps

module time_ordered_event_queue_tb;

  localparam int CAPACITY   = toeq_pkg::CAPACITY_DEF;
  localparam int TIME_BITS  = toeq_pkg::TIME_BITS_DEF;
  localparam int TAG_BITS   = toeq_pkg::TAG_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    toeq_pkg::action_e     action;
    logic [TIME_BITS-1:0]  ev_time;
    logic [TAG_BITS-1:0]   ev_tag;
  } event_cmd_t;

  typedef struct packed {
    logic [toeq_pkg::STATUS_BITS-1:0] status;
    logic [TIME_BITS-1:0]             ev_time;
    logic [TAG_BITS-1:0]              ev_tag;
    logic [toeq_pkg::OCC_BITS-1:0]    occ;
  } queue_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       cmd_valid = 1'b0;
  event_cmd_t bus_cmd   = '{action: toeq_pkg::ACT_NOP, ev_time: '0, ev_tag: '0};
  logic       reply_stall = 1'b0;

  logic                             in_stall_o;
  logic                             out_valid_o;
  logic [toeq_pkg::STATUS_BITS-1:0] status_o;
  logic [TIME_BITS-1:0]             out_time_o;
  logic [TAG_BITS-1:0]              out_tag_o;
  logic [toeq_pkg::OCC_BITS-1:0]    occupancy_o;

  // commands waiting to be sent and replies waiting to arrive
  event_cmd_t   event_cmds[$];
  queue_reply_t due_replies[$];
  queue_reply_t want_reply;

  // shadow copy of the sorted queue
  logic [TIME_BITS-1:0] shadow_times[$];
  logic [TAG_BITS-1:0]  shadow_tags[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  time_ordered_event_queue DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_valid),
    .in_stall_o   (in_stall_o),
    .action_i     (bus_cmd.action),
    .event_time_i (bus_cmd.ev_time),
    .event_tag_i  (bus_cmd.ev_tag),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (reply_stall),
    .status_o     (status_o),
    .out_time_o   (out_time_o),
    .out_tag_o    (out_tag_o),
    .occupancy_o  (occupancy_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // apply one command to the shadow queue and return the reply it should give
  function automatic queue_reply_t apply_to_shadow_queue(event_cmd_t c);
    queue_reply_t r;
    int pos;
    r = '{status: toeq_pkg::ST_OK, ev_time: '0, ev_tag: '0, occ: '0};
    pos = 0;
    case (c.action)
      toeq_pkg::ACT_INSERT: begin
        if (shadow_times.size() >= CAPACITY) begin
          r.status = toeq_pkg::ST_FULL;
        end else begin
          // behind every event of equal or earlier time
          while (pos < shadow_times.size() && shadow_times[pos] <= c.ev_time) pos++;
          shadow_times.insert(pos, c.ev_time);
          shadow_tags.insert(pos, c.ev_tag);
        end
      end
      toeq_pkg::ACT_POP: begin
        if (shadow_times.size() == 0) begin
          r.status = toeq_pkg::ST_EMPTY;
        end else begin
          r.ev_time = shadow_times.pop_front();
          r.ev_tag  = shadow_tags.pop_front();
        end
      end
      toeq_pkg::ACT_REMOVE: begin
        // first match in queue order
        while (pos < shadow_tags.size() && shadow_tags[pos] != c.ev_tag) pos++;
        if (pos < shadow_tags.size()) begin
          shadow_times.delete(pos);
          shadow_tags.delete(pos);
        end else begin
          r.status = toeq_pkg::ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    r.occ = toeq_pkg::OCC_BITS'(shadow_times.size());
    return r;
  endfunction

  task automatic add_cmd(toeq_pkg::action_e a, logic [TIME_BITS-1:0] t,
                         logic [TAG_BITS-1:0] g);
    event_cmds.push_back('{action: a, ev_time: t, ev_tag: g});
  endtask

  // random commands; mostly small times and tags so ties and tag hits are common
  task automatic add_random_cmds(int n, int ins_pct, int pop_pct);
    int r;
    toeq_pkg::action_e a;
    logic [TIME_BITS-1:0] t;
    logic [TAG_BITS-1:0] g;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < ins_pct) a = toeq_pkg::ACT_INSERT;
      else if (r < ins_pct + pop_pct) a = toeq_pkg::ACT_POP;
      else if (r < 96) a = toeq_pkg::ACT_REMOVE;
      else a = toeq_pkg::ACT_NOP;
      if ($urandom_range(7) == 0) t = TIME_BITS'({$urandom, $urandom});
      else t = TIME_BITS'($urandom_range(31));
      if ($urandom_range(7) == 0) g = TAG_BITS'($urandom);
      else g = TAG_BITS'($urandom_range(15));
      add_cmd(a, t, g);
    end
  endtask

  // driver: predicts each accepted command, then offers the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid <= 1'b0;
      bus_cmd   <= '{action: toeq_pkg::ACT_NOP, ev_time: '0, ev_tag: '0};
    end else begin
      if (cmd_valid && !in_stall_o) due_replies.push_back(apply_to_shadow_queue(bus_cmd));
      if (!cmd_valid || !in_stall_o) begin
        if (event_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bus_cmd   <= event_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each reply transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_stall <= 1'b0;
    end else begin
      if (out_valid_o && !reply_stall) begin
        if (due_replies.size() == 0) begin
          $error("reply transfer with no command outstanding");
          mismatches++;
        end else begin
          want_reply = due_replies.pop_front();
          if (status_o !== want_reply.status) begin
            $error("status: expected %0d, got %0d", want_reply.status, status_o);
            mismatches++;
          end
          if (out_time_o !== want_reply.ev_time) begin
            $error("out_time: expected %0h, got %0h", want_reply.ev_time, out_time_o);
            mismatches++;
          end
          if (out_tag_o !== want_reply.ev_tag) begin
            $error("out_tag: expected %0h, got %0h", want_reply.ev_tag, out_tag_o);
            mismatches++;
          end
          if (occupancy_o !== want_reply.occ) begin
            $error("occupancy: expected %0d, got %0d", want_reply.occ, occupancy_o);
            mismatches++;
          end
        end
      end
      reply_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  <= (phase == 0) ? 23 : (phase == 1) ? 85 : 0;
      recv_stall_pct <= (phase == 0) ? 85 : (phase == 1) ? 23 : 0;

      if (phase == 0) begin
        // empty queue corner cases and the unused action
        add_cmd(toeq_pkg::ACT_POP, '0, '0);
        add_cmd(toeq_pkg::ACT_REMOVE, '0, '0);
        add_cmd(toeq_pkg::ACT_NOP, '1, '1);
        // field extremes, ties and duplicated tags
        add_cmd(toeq_pkg::ACT_INSERT, '1, '1);
        add_cmd(toeq_pkg::ACT_INSERT, '0, '0);
        add_cmd(toeq_pkg::ACT_INSERT, TIME_BITS'(100), TAG_BITS'(7));
        add_cmd(toeq_pkg::ACT_INSERT, TIME_BITS'(100), TAG_BITS'(8));
        add_cmd(toeq_pkg::ACT_INSERT, TIME_BITS'(100), TAG_BITS'(7));
        add_cmd(toeq_pkg::ACT_INSERT, TIME_BITS'(50), TAG_BITS'(7));
        add_cmd(toeq_pkg::ACT_REMOVE, '0, TAG_BITS'(7));
        add_cmd(toeq_pkg::ACT_REMOVE, '0, TAG_BITS'(200));
        add_cmd(toeq_pkg::ACT_NOP, '0, '0);
        repeat (6) add_cmd(toeq_pkg::ACT_POP, '0, '0);
        add_cmd(toeq_pkg::ACT_REMOVE, '0, '1);
      end

      // fill past capacity, drain past empty, then mixed traffic
      add_random_cmds(100, 85, 6);
      add_random_cmds(90, 15, 50);
      repeat (3) add_random_cmds(20, $urandom_range(35, 65), 25);

      // hold off until every reply of this phase is back
      while (event_cmds.size() != 0 || cmd_valid || due_replies.size() != 0)
        @(posedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && due_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
